FILE: rtl/core/drld_pkg.sv
// Package for the data run list decoder: beat structs, parse phase codes
// and the delta sign-extension helper. No dependencies.
`default_nettype none

package drld_pkg;

    localparam int unsigned MAX_FIELD_BYTES = 8;
    localparam int unsigned SIZE_W          = 4;
    localparam int unsigned WORD_W          = 64;

    typedef enum logic [1:0] {
        PHASE_HEADER = 2'd0,
        PHASE_LENGTH = 2'd1,
        PHASE_OFFSET = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] run_byte;
        logic       list_start;
    } run_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] run_length;
        logic [WORD_W-1:0] start_cluster;
        logic              sparse_run;
        logic              end_of_list;
        logic              size_error;
    } result_beat_t;

    // Sign-extends a little-endian delta of size bytes (1 to 8) to 64 bits.
    // Bytes at and above size are known to be zero in the input value.
    function automatic logic [WORD_W-1:0] sign_extend(
        input logic [WORD_W-1:0] value,
        input logic [SIZE_W-1:0] size
    );
        logic              sign;
        logic [WORD_W-1:0] result;
        sign   = 1'b0;
        result = value;
        for (int i = 0; i < MAX_FIELD_BYTES; i++) begin
            if (size == SIZE_W'(i + 1)) begin
                sign = value[8*i+7];
            end
        end
        for (int i = 0; i < MAX_FIELD_BYTES; i++) begin
            if (SIZE_W'(i) >= size) begin
                result[8*i +: 8] = {8{sign}};
            end
        end
        return result;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/data_run_list_decoder.sv
// Data run list decoder: parses a mapping-pairs run list one byte per beat.
// Depends on drld_pkg for the beat structs, phase codes and sign extension.
//
// Usage:
// The run channel (run_valid, run_stall, run_data) carries one list byte per
// beat; list_start marks the first byte of a new list and clears the running
// cluster. The result channel (result_valid, result_stall, result_data)
// carries one beat for each finished run, for the zero header byte that ends
// a list, and for a header whose field size exceeds eight bytes.
// A byte is accepted in every cycle the result register can take a beat:
// run_stall is high only while a result is held and result_stall is high.
// The result of a byte appears in the result register in the cycle after the
// byte is accepted. The longest path is the 64-bit add of the sign-extended
// delta into the running cluster, done in the cycle of the last offset byte.
// Bytes that arrive after the end of a list, without list_start, are
// swallowed without a result. Reset returns the parser to the header phase
// with a zero running cluster and an empty result register.
`default_nettype none

module data_run_list_decoder (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   run_valid,
    output logic                        run_stall,
    input  wire drld_pkg::run_beat_t    run_data,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output drld_pkg::result_beat_t      result_data
);

    drld_pkg::phase_t                      phase_reg, phase_next;
    logic [drld_pkg::SIZE_W-1:0]           len_size_reg, len_size_next;
    logic [drld_pkg::SIZE_W-1:0]           off_size_reg, off_size_next;
    logic [drld_pkg::SIZE_W-1:0]           pos_reg, pos_next;
    logic [drld_pkg::WORD_W-1:0]           len_acc_reg, len_acc_next;
    logic [drld_pkg::WORD_W-1:0]           delta_acc_reg, delta_acc_next;
    logic [drld_pkg::WORD_W-1:0]           running_reg, running_next;
    logic                                  finished_reg, finished_next;
    logic                                  result_valid_reg, result_valid_next;
    drld_pkg::result_beat_t                result_data_reg, result_data_next;

    logic                                  accept;
    logic [7:0]                            b;
    drld_pkg::phase_t                      eff_phase;
    logic                                  eff_finished;
    logic [drld_pkg::WORD_W-1:0]           eff_running;
    logic [drld_pkg::WORD_W-1:0]           byte_shifted;
    logic [drld_pkg::WORD_W-1:0]           len_merged;
    logic [drld_pkg::WORD_W-1:0]           delta_merged;
    logic [drld_pkg::WORD_W-1:0]           cluster_sum;
    logic [drld_pkg::SIZE_W-1:0]           pos_inc;
    logic                                  len_done;
    logic                                  off_done;
    logic                                  hdr_err;

    assign run_stall    = result_valid_reg && result_stall;
    assign accept       = run_valid && !run_stall;
    assign b            = run_data.run_byte;
    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // A list_start beat is parsed as a header of a fresh list.
    assign eff_phase    = run_data.list_start ? drld_pkg::PHASE_HEADER : phase_reg;
    assign eff_finished = run_data.list_start ? 1'b0 : finished_reg;
    assign eff_running  = run_data.list_start ? '0 : running_reg;

    assign byte_shifted = drld_pkg::WORD_W'(b) << {pos_reg[2:0], 3'b000};
    assign len_merged   = len_acc_reg | byte_shifted;
    assign delta_merged = delta_acc_reg | byte_shifted;
    assign pos_inc      = pos_reg + drld_pkg::SIZE_W'(1);
    assign len_done     = pos_inc >= len_size_reg;
    assign off_done     = pos_inc >= off_size_reg;
    assign cluster_sum  = running_reg + drld_pkg::sign_extend(delta_merged, off_size_reg);
    assign hdr_err      = (b[3:0] > drld_pkg::SIZE_W'(drld_pkg::MAX_FIELD_BYTES))
                       || (b[7:4] > drld_pkg::SIZE_W'(drld_pkg::MAX_FIELD_BYTES));

    always_comb
    begin : phase_logic
        phase_next = phase_reg;
        if (accept)
        begin
            phase_next = eff_phase;
            if (!eff_finished)
            begin
                case (eff_phase)
                    drld_pkg::PHASE_LENGTH:
                    begin
                        if (len_done)
                        begin
                            phase_next = (off_size_reg == '0) ? drld_pkg::PHASE_HEADER
                                                               : drld_pkg::PHASE_OFFSET;
                        end
                    end
                    drld_pkg::PHASE_OFFSET:
                    begin
                        if (off_done)
                        begin
                            phase_next = drld_pkg::PHASE_HEADER;
                        end
                    end
                    drld_pkg::PHASE_HEADER:
                    begin
                        if (b == 8'd0 || hdr_err)
                        begin
                            phase_next = drld_pkg::PHASE_HEADER;
                        end
                        else if (b[3:0] != '0)
                        begin
                            phase_next = drld_pkg::PHASE_LENGTH;
                        end
                        else
                        begin
                            phase_next = drld_pkg::PHASE_OFFSET;
                        end
                    end
                    default:
                    begin
                        phase_next = drld_pkg::PHASE_HEADER;
                    end
                endcase
            end
        end
    end

    always_comb
    begin : datapath_logic
        len_size_next     = len_size_reg;
        off_size_next     = off_size_reg;
        pos_next          = pos_reg;
        len_acc_next      = len_acc_reg;
        delta_acc_next    = delta_acc_reg;
        running_next      = running_reg;
        finished_next     = finished_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_data_next  = result_data_reg;

        if (accept)
        begin
            running_next  = eff_running;
            finished_next = eff_finished;
            if (run_data.list_start)
            begin
                pos_next = '0;
            end
            if (!eff_finished)
            begin
                case (eff_phase)
                    drld_pkg::PHASE_LENGTH:
                    begin
                        len_acc_next = len_merged;
                        pos_next     = pos_inc;
                        if (len_done)
                        begin
                            pos_next = '0;
                            if (off_size_reg == '0)
                            begin
                                result_valid_next              = 1'b1;
                                result_data_next.run_length    = len_merged;
                                result_data_next.start_cluster = running_reg;
                                result_data_next.sparse_run    = 1'b1;
                                result_data_next.end_of_list   = 1'b0;
                                result_data_next.size_error    = 1'b0;
                            end
                        end
                    end
                    drld_pkg::PHASE_OFFSET:
                    begin
                        delta_acc_next = delta_merged;
                        pos_next       = pos_inc;
                        if (off_done)
                        begin
                            pos_next                       = '0;
                            running_next                   = cluster_sum;
                            result_valid_next              = 1'b1;
                            result_data_next.run_length    = len_acc_reg;
                            result_data_next.start_cluster = cluster_sum;
                            result_data_next.sparse_run    = 1'b0;
                            result_data_next.end_of_list   = 1'b0;
                            result_data_next.size_error    = 1'b0;
                        end
                    end
                    default:
                    begin
                        if (b == 8'd0)
                        begin
                            finished_next                  = 1'b1;
                            result_valid_next              = 1'b1;
                            result_data_next.run_length    = '0;
                            result_data_next.start_cluster = '0;
                            result_data_next.sparse_run    = 1'b0;
                            result_data_next.end_of_list   = 1'b1;
                            result_data_next.size_error    = 1'b0;
                        end
                        else
                        begin
                            len_size_next  = b[3:0];
                            off_size_next  = b[7:4];
                            len_acc_next   = '0;
                            delta_acc_next = '0;
                            pos_next       = '0;
                            if (hdr_err)
                            begin
                                finished_next                  = 1'b1;
                                result_valid_next              = 1'b1;
                                result_data_next.run_length    = '0;
                                result_data_next.start_cluster = '0;
                                result_data_next.sparse_run    = 1'b0;
                                result_data_next.end_of_list   = 1'b0;
                                result_data_next.size_error    = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= drld_pkg::PHASE_HEADER;
            len_size_reg     <= '0;
            off_size_reg     <= '0;
            pos_reg          <= '0;
            len_acc_reg      <= '0;
            delta_acc_reg    <= '0;
            running_reg      <= '0;
            finished_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            len_size_reg     <= len_size_next;
            off_size_reg     <= off_size_next;
            pos_reg          <= pos_next;
            len_acc_reg      <= len_acc_next;
            delta_acc_reg    <= delta_acc_next;
            running_reg      <= running_next;
            finished_reg     <= finished_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_data_reg <= result_data_next;
    end

`ifndef SYNTHESIS
    // The input side only waits on a held result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        run_stall |-> result_valid_reg)
        else $error("run_stall raised without a pending result beat");

    // While collecting length bytes the position stays inside the field.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == drld_pkg::PHASE_LENGTH) |-> (pos_reg < len_size_reg))
        else $error("length byte position beyond field size");

    // The offset phase is only entered for a nonzero offset field.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == drld_pkg::PHASE_OFFSET)
            |-> (off_size_reg != '0 && pos_reg < off_size_reg))
        else $error("offset phase with empty or overrun offset field");

    // A finished list always parks the parser in the header phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> (phase_reg == drld_pkg::PHASE_HEADER))
        else $error("list finished outside header phase");

    // End and error beats carry zero length and cluster.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (result_data_reg.end_of_list || result_data_reg.size_error))
            |-> (result_data_reg.run_length == '0 && result_data_reg.start_cluster == '0))
        else $error("terminating result beat carries run data");
`endif

endmodule

`default_nettype wire

FILE: tb/data_run_list_decoder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for data_run_list_decoder: a directed table and random run lists,
// with each result beat checked against a behavioral run list decoder or a fixed expected beat.
// Depends on drld_pkg and the data_run_list_decoder RTL.

module data_run_list_decoder_tb;

    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 350;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_END,
        CHK_ERR,
        CHK_MAX
    } row_check_t;

    typedef struct packed {
        logic [7:0] run_byte;
        logic       list_start;
        row_check_t check;
    } stim_row_t;

    // Directed list: an end marker, a byte after the end, the widest run with all-ones
    // fields, a sparse run, an empty length field, and a run cut short by an oversized header.
    localparam stim_row_t DIRECTED [25] = '{
        '{8'h00, 1'b1, CHK_END},
        '{8'h05, 1'b0, CHK_PREDICT},
        '{8'h88, 1'b1, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_PREDICT},
        '{8'hFF, 1'b0, CHK_MAX},
        '{8'h01, 1'b0, CHK_PREDICT},
        '{8'h7F, 1'b0, CHK_PREDICT},
        '{8'h10, 1'b0, CHK_PREDICT},
        '{8'h7F, 1'b0, CHK_PREDICT},
        '{8'h21, 1'b0, CHK_PREDICT},
        '{8'h09, 1'b1, CHK_ERR}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   run_valid;
    logic                   run_stall;
    drld_pkg::run_beat_t    run_data;
    logic                   result_valid;
    logic                   result_stall;
    drld_pkg::result_beat_t result_data;

    data_run_list_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .run_valid    (run_valid),
        .run_stall    (run_stall),
        .run_data     (run_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    stim_row_t              byte_stream[$];
    drld_pkg::result_beat_t expected_runs[$];
    int           sent_bytes;
    int           accepted_bytes;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           hold_req;
    int           idle_cycles;
    int           failures;
    int           seen_runs;
    int           seen_sparse;
    int           seen_ends;
    int           seen_errors;

    // Decoder state as the testbench tracks it.
    drld_pkg::phase_t stage;
    logic [3:0]   len_bytes;
    logic [3:0]   off_bytes;
    logic [3:0]   pos;
    logic [63:0]  length_sum;
    logic [63:0]  delta_sum;
    logic [63:0]  cur_cluster;
    logic         list_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic drld_pkg::result_beat_t close_run();
        drld_pkg::result_beat_t r;
        logic [63:0]  delta;
        int unsigned  nbits;
        r = '0;
        nbits = off_bytes * 8;
        if (off_bytes == 4'd0)
        begin
            r.sparse_run = 1'b1;
        end
        else
        begin
            delta = delta_sum;
            if (nbits < 64 && delta[nbits - 1])
            begin
                delta |= {64{1'b1}} << nbits;
            end
            cur_cluster += delta;
        end
        r.run_length    = length_sum;
        r.start_cluster = cur_cluster;
        stage = drld_pkg::PHASE_HEADER;
        pos   = '0;
        return r;
    endfunction

    function automatic bit decode_byte(input drld_pkg::run_beat_t b,
                                       output drld_pkg::result_beat_t r);
        logic [63:0] shifted;
        r = '0;
        shifted = 64'(b.run_byte) << (8 * pos[2:0]);
        if (b.list_start)
        begin
            cur_cluster = '0;
            list_done   = 1'b0;
            stage       = drld_pkg::PHASE_HEADER;
            pos         = '0;
        end
        if (list_done)
        begin
            return 1'b0;
        end
        case (stage)
            drld_pkg::PHASE_LENGTH:
            begin
                length_sum |= shifted;
                pos++;
                if (pos >= len_bytes)
                begin
                    pos = '0;
                    if (off_bytes == 4'd0)
                    begin
                        r = close_run();
                        return 1'b1;
                    end
                    stage = drld_pkg::PHASE_OFFSET;
                end
                return 1'b0;
            end
            drld_pkg::PHASE_OFFSET:
            begin
                delta_sum |= shifted;
                pos++;
                if (pos >= off_bytes)
                begin
                    r = close_run();
                    return 1'b1;
                end
                return 1'b0;
            end
            default:
            begin
                if (b.run_byte == 8'h00)
                begin
                    list_done     = 1'b1;
                    r.end_of_list = 1'b1;
                    return 1'b1;
                end
                len_bytes  = b.run_byte[3:0];
                off_bytes  = b.run_byte[7:4];
                length_sum = '0;
                delta_sum  = '0;
                pos        = '0;
                if (len_bytes > drld_pkg::MAX_FIELD_BYTES
                    || off_bytes > drld_pkg::MAX_FIELD_BYTES)
                begin
                    list_done    = 1'b1;
                    stage        = drld_pkg::PHASE_HEADER;
                    r.size_error = 1'b1;
                    return 1'b1;
                end
                stage = (len_bytes != 4'd0) ? drld_pkg::PHASE_LENGTH : drld_pkg::PHASE_OFFSET;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic s);
        stim_row_t row;
        row.run_byte   = b;
        row.list_start = s;
        row.check      = CHK_PREDICT;
        byte_stream.push_back(row);
    endfunction

    // Mostly well-formed lists; some end in an oversized header, some are cut
    // mid-run by the next list, and a few are plain noise.
    task automatic add_random_list();
        int         runs;
        int         lb;
        int         ob;
        int         cut;
        logic       first;
        logic [3:0] tmp;
        if ($urandom_range(99) < 5)
        begin
            repeat ($urandom_range(1, 8))
            begin
                push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            return;
        end
        first = 1'b1;
        runs = $urandom_range(0, 6);
        for (int k = 0; k < runs; k++)
        begin
            if ($urandom_range(99) < 5)
            begin
                lb = $urandom_range(drld_pkg::MAX_FIELD_BYTES + 1, 15);
                ob = $urandom_range(0, 15);
                if ($urandom_range(1))
                begin
                    tmp = 4'(lb);
                    lb  = ob;
                    ob  = tmp;
                end
                push_byte({4'(ob), 4'(lb)}, first);
                repeat ($urandom_range(0, 3))
                begin
                    push_byte(8'($urandom_range(255)), 1'b0);
                end
                return;
            end
            lb = $urandom_range(0, drld_pkg::MAX_FIELD_BYTES);
            ob = $urandom_range(0, drld_pkg::MAX_FIELD_BYTES);
            if (lb == 0 && ob == 0)
            begin
                lb = 1;
            end
            push_byte({4'(ob), 4'(lb)}, first);
            first = 1'b0;
            cut = ($urandom_range(99) < 4) ? $urandom_range(0, lb + ob - 1) : lb + ob;
            repeat (cut)
            begin
                push_byte(8'($urandom_range(255)), 1'b0);
            end
            if (cut < lb + ob)
            begin
                return;
            end
        end
        push_byte(8'h00, first);
        repeat ($urandom_range(0, 2))
        begin
            push_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // Entered and left at a falling edge; valid stays high until the beat is taken.
    task automatic send_item(input stim_row_t row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            run_valid <= 1'b0;
            @(negedge clk);
        end
        run_valid           <= 1'b1;
        run_data.run_byte   <= row.run_byte;
        run_data.list_start <= row.list_start;
        @(posedge clk);
        while (run_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic feed_stream(input int hold_at);
        while (sent_bytes < byte_stream.size())
        begin
            if (sent_bytes == hold_at)
            begin
                hold_req = 1'b1;
            end
            send_item(byte_stream[sent_bytes]);
            sent_bytes++;
        end
    endtask

    task automatic drain();
        run_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (expected_runs.size() != 0);
    endtask

    initial
    begin
        int mark;
        rst_n          = 1'b0;
        run_valid      = 1'b0;
        run_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        sent_bytes     = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        foreach (DIRECTED[i])
        begin
            byte_stream.push_back(DIRECTED[i]);
        end
        feed_stream(-1);
        drain();
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            mark = byte_stream.size();
            while (byte_stream.size() - mark < PHASE_ITEMS)
            begin
                add_random_list();
            end
            // In the free-flowing phase, hold results off long enough to back up the input.
            feed_stream((p == 0) ? mark + 100 : -1);
            drain();
        end
        repeat (4) @(negedge clk);
        $display("Covered %0d list bytes: %0d runs (%0d sparse), %0d list ends, %0d size errors.",
                 accepted_bytes, seen_runs, seen_sparse, seen_ends, seen_errors);
        $display("Flow control: free flow, sender gaps, receiver stalls, both, long hold-off.");
        if (failures == 0)
        begin
            $display("data_run_list_decoder_tb passed");
        end
        else
        begin
            $display("data_run_list_decoder_tb failed");
        end
        $finish;
    end

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        drld_pkg::result_beat_t got;
        drld_pkg::result_beat_t want;
        drld_pkg::result_beat_t predicted;
        stim_row_t    row;
        bit           produced;
        if (rst_n)
        begin
            if ((result_valid && !result_stall) || (run_valid && !run_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("data_run_list_decoder_tb failed");
                $finish;
            end

            if (result_valid && !result_stall)
            begin
                got = result_data;
                if (expected_runs.size() == 0)
                begin
                    $error("result beat with nothing expected: %p", got);
                    failures++;
                end
                else
                begin
                    want = expected_runs.pop_front();
                    if (got.run_length !== want.run_length)
                    begin
                        $error("run_length: expected %h, got %h", want.run_length, got.run_length);
                        failures++;
                    end
                    if (got.start_cluster !== want.start_cluster)
                    begin
                        $error("start_cluster: expected %h, got %h",
                               want.start_cluster, got.start_cluster);
                        failures++;
                    end
                    if (got.sparse_run !== want.sparse_run)
                    begin
                        $error("sparse_run: expected %b, got %b", want.sparse_run, got.sparse_run);
                        failures++;
                    end
                    if (got.end_of_list !== want.end_of_list)
                    begin
                        $error("end_of_list: expected %b, got %b",
                               want.end_of_list, got.end_of_list);
                        failures++;
                    end
                    if (got.size_error !== want.size_error)
                    begin
                        $error("size_error: expected %b, got %b", want.size_error, got.size_error);
                        failures++;
                    end
                    if (want.end_of_list)
                    begin
                        seen_ends++;
                    end
                    else if (want.size_error)
                    begin
                        seen_errors++;
                    end
                    else
                    begin
                        seen_runs++;
                        seen_sparse += want.sparse_run;
                    end
                end
            end

            if (run_valid && !run_stall)
            begin
                row = byte_stream[accepted_bytes];
                accepted_bytes++;
                produced = decode_byte(run_data, predicted);
                want = '0;
                case (row.check)
                    CHK_END:
                    begin
                        want.end_of_list = 1'b1;
                        expected_runs.push_back(want);
                    end
                    CHK_ERR:
                    begin
                        want.size_error = 1'b1;
                        expected_runs.push_back(want);
                    end
                    CHK_MAX:
                    begin
                        want.run_length    = {64{1'b1}};
                        want.start_cluster = {64{1'b1}};
                        expected_runs.push_back(want);
                    end
                    default:
                    begin
                        if (produced)
                        begin
                            expected_runs.push_back(predicted);
                        end
                    end
                endcase
            end
        end
    end

    initial
    begin
        stage          = drld_pkg::PHASE_HEADER;
        len_bytes      = '0;
        off_bytes      = '0;
        pos            = '0;
        length_sum     = '0;
        delta_sum      = '0;
        cur_cluster    = '0;
        list_done      = 1'b0;
        accepted_bytes = 0;
        idle_cycles    = 0;
        failures       = 0;
        seen_runs      = 0;
        seen_sparse    = 0;
        seen_ends      = 0;
        seen_errors    = 0;
    end

endmodule
